// ----- src/whf_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted histogram fill package
// Opcodes and fixed-point constants shared by the core and its checker.
// ----------------------------------------------------------------------------
package whf_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_CLEAR = 2'd0;
  localparam opcode_t OP_LOAD  = 2'd1;
  localparam opcode_t OP_ADD   = 2'd2;
  localparam opcode_t OP_READ  = 2'd3;

  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;
  localparam logic [6:0]  DIV_LAST = 7'd95;
  localparam logic [4:0]  SQRT_LAST = 5'd31;

endpackage

// ----- src/weighted_histogram_fill_core.sv -----
// ----------------------------------------------------------------------------
// Weighted histogram fill core
// Variable-width weighted histogram with under- and overflow bins.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; opcode selects clear,
// load edge, add sample or read bin. Each request gives one result, shown for
// one cycle with result_valid; the receiver cannot stall it.
// Clear and load edge are answered in the cycle after they are taken.
// Add sample searches the edge table one entry a cycle, multiplies on a
// shared 32 by 32 multiplier, and in a regular bin runs two 96-step
// restoring divisions. Read bin, unless it ends early, runs five multiplier
// passes, one 96-step division by the event count less one, and a 32-step
// square root.
// The single configuration register bins_in_use is written through cfg_valid
// and cfg_ready while the core is idle. Reset zeros all edges, sums and the
// event count at once through per-entry valid bits, and sets bins_in_use to 8.
// ----------------------------------------------------------------------------
module weighted_histogram_fill_core #(
  parameter int MAX_BINS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  whf_pkg::opcode_t     opcode,
  input  logic [6:0]           slot,
  input  logic signed [31:0]   sample_value,
  input  logic signed [31:0]   sample_weight,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data,
  output logic                 result_valid,
  output logic [6:0]           landed_bin,
  output logic signed [63:0]   bin_sum,
  output logic [62:0]          bin_square_sum,
  output logic [31:0]          bin_deviation,
  output logic [31:0]          events_seen
);
  import whf_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS + 2);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SRCH    = 4'd1;
  localparam logic [3:0] ST_RD_WAIT = 4'd2;
  localparam logic [3:0] ST_RD_GET  = 4'd3;
  localparam logic [3:0] ST_MUL     = 4'd4;
  localparam logic [3:0] ST_PREP    = 4'd5;
  localparam logic [3:0] ST_DIV     = 4'd6;
  localparam logic [3:0] ST_DFIN    = 4'd7;
  localparam logic [3:0] ST_SQRT    = 4'd8;
  localparam logic [3:0] ST_UPD     = 4'd9;

  logic [3:0]       state;
  opcode_t          op_r;
  logic [6:0]       slot_r;
  logic [31:0]      val_r;
  logic             neg_r;
  logic [31:0]      mag_r;
  logic [IDX_W-1:0] bin;
  logic [31:0]      prev_e;
  logic [31:0]      w_r;
  logic [31:0]      cnt;
  logic [6:0]       bins_cfg;
  logic [2:0]       mstep;
  logic [95:0]      acc_a;
  logic [127:0]     acc_b;
  logic [63:0]      prod;
  logic [95:0]      dv_d;
  logic [63:0]      dv_rem;
  logic [63:0]      dv_den;
  logic [6:0]       dv_cnt;
  logic             djob;
  logic [63:0]      ds_r;
  logic [62:0]      dq_r;
  logic [63:0]      s_r;
  logic [62:0]      s2_r;
  logic [63:0]      sq_x;
  logic [63:0]      sq_res;
  logic [63:0]      sq_bit;
  logic [4:0]       sq_cnt;

  logic [31:0] edge_mem [0:MAX_BINS];
  logic [MAX_BINS:0] edge_vld;
  logic [31:0] edge_q;
  logic        edge_qv;
  logic [63:0] sum_mem [0:MAX_BINS+1];
  logic [62:0] sq_mem [0:MAX_BINS+1];
  logic [MAX_BINS+1:0] sum_vld;
  logic [63:0] sum_q;
  logic [62:0] sq_q;
  logic        sum_qv;

  logic             accept;
  logic [IDX_W-1:0] n_act;
  logic [IDX_W-1:0] ed_raddr;
  logic             ed_we;
  logic             sum_we;
  logic [31:0]      e_cur;
  logic [63:0]      mag_s;
  logic             is_dev;
  logic [2:0]       nops;
  logic [2:0]       psel;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [7:0]       acc_sh;
  logic             acc_to_a;
  logic [127:0]     acc_term;
  logic [64:0]      dv_r2;
  logic             dv_ge;
  logic [127:0]     a128;
  logic [127:0]     diff;
  logic [63:0]      sq_t;
  logic [63:0]      sq_res_next;
  logic [63:0]      old_s;
  logic [62:0]      old_q;
  logic [63:0]      ds_pos;
  logic [63:0]      ds_eff;
  logic [63:0]      sum_raw;
  logic [63:0]      new_s;
  logic [63:0]      sq_raw;
  logic [62:0]      new_q;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  always_comb begin
    if (bins_cfg == 7'd0) begin
      n_act = IDX_W'(1);
    end else if ({25'd0, bins_cfg} > 32'(MAX_BINS)) begin
      n_act = IDX_W'(MAX_BINS);
    end else begin
      n_act = IDX_W'(bins_cfg);
    end
  end

  assign ed_raddr = (state == ST_SRCH && bin != n_act) ? bin + IDX_W'(1) : '0;
  assign ed_we    = accept && opcode == OP_LOAD && {25'd0, slot} <= 32'(MAX_BINS);
  assign sum_we   = (state == ST_UPD);
  assign e_cur    = edge_qv ? edge_q : 32'd0;

  always_ff @(posedge clk) begin
    if (ed_we) begin
      edge_mem[IDX_W'(slot)] <= sample_value;
    end
    edge_q  <= edge_mem[ed_raddr];
    edge_qv <= edge_vld[ed_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[bin] <= new_s;
      sq_mem[bin]  <= new_q;
    end
    sum_q  <= sum_mem[bin];
    sq_q   <= sq_mem[bin];
    sum_qv <= sum_vld[bin];
  end

  // Multiplier operand schedule: the read path builds N*S2 and S*S, the add
  // path the squared weight and the squared bin width.
  assign is_dev = (op_r == OP_READ);
  assign nops   = is_dev ? 3'd5 : 3'd2;
  assign psel   = mstep - 3'd1;
  assign mag_s  = s_r[63] ? (64'd0 - s_r) : s_r;

  always_comb begin
    mul_a = mag_r;
    mul_b = mag_r;
    if (is_dev) begin
      unique case (mstep)
        3'd0: begin mul_a = cnt; mul_b = s2_r[31:0]; end
        3'd1: begin mul_a = cnt; mul_b = {1'b0, s2_r[62:32]}; end
        3'd2: begin mul_a = mag_s[31:0]; mul_b = mag_s[31:0]; end
        3'd3: begin mul_a = mag_s[31:0]; mul_b = mag_s[63:32]; end
        default: begin mul_a = mag_s[63:32]; mul_b = mag_s[63:32]; end
      endcase
    end else if (mstep == 3'd1) begin
      mul_a = w_r;
      mul_b = w_r;
    end
  end

  always_comb begin
    acc_sh   = 8'd0;
    acc_to_a = 1'b0;
    if (is_dev) begin
      case (psel)
        3'd0: begin acc_sh = 8'd0;  acc_to_a = 1'b1; end
        3'd1: begin acc_sh = 8'd32; acc_to_a = 1'b1; end
        3'd2: acc_sh = 8'd0;
        3'd3: acc_sh = 8'd33;
        default: acc_sh = 8'd64;
      endcase
    end else begin
      acc_to_a = (psel == 3'd1);
    end
    acc_term = {64'd0, prod} << acc_sh;
  end

  assign dv_r2 = {dv_rem, dv_d[95]};
  assign dv_ge = (dv_r2 >= {1'b0, dv_den});
  assign a128  = {acc_a, 32'd0};
  assign diff  = a128 - acc_b;

  assign sq_t = sq_res + sq_bit;
  assign sq_res_next = (sq_x >= sq_t) ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  always_comb begin
    old_s   = sum_qv ? sum_q : 64'd0;
    old_q   = sum_qv ? sq_q : 63'd0;
    ds_pos  = (!neg_r && ds_r[63]) ? SUM_MAX : ds_r;
    ds_eff  = neg_r ? (64'd0 - ds_pos) : ds_pos;
    sum_raw = old_s + ds_eff;
    if (old_s[63] == ds_eff[63] && sum_raw[63] != old_s[63]) begin
      new_s = old_s[63] ? SUM_MIN : SUM_MAX;
    end else begin
      new_s = sum_raw;
    end
    sq_raw = {1'b0, old_q} + {1'b0, dq_r};
    new_q  = sq_raw[63] ? SUM_MAX[62:0] : sq_raw[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= 32'd0;
      bins_cfg     <= 7'd8;
      edge_vld     <= '0;
      sum_vld      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        bins_cfg <= cfg_data;
      end
      if (ed_we) begin
        edge_vld[IDX_W'(slot)] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r   <= opcode;
            slot_r <= slot;
            val_r  <= sample_value;
            neg_r  <= sample_weight[31];
            mag_r  <= sample_weight[31] ? (32'd0 - sample_weight) : sample_weight;
            bin    <= '0;
            prev_e <= 32'd0;
            unique case (opcode)
              OP_CLEAR: begin
                sum_vld        <= '0;
                cnt            <= 32'd0;
                result_valid   <= 1'b1;
                landed_bin     <= 7'd0;
                bin_sum        <= 64'd0;
                bin_square_sum <= 63'd0;
                bin_deviation  <= 32'd0;
                events_seen    <= 32'd0;
              end
              OP_LOAD: begin
                result_valid   <= 1'b1;
                landed_bin     <= slot;
                bin_sum        <= 64'd0;
                bin_square_sum <= 63'd0;
                bin_deviation  <= 32'd0;
                events_seen    <= cnt;
              end
              OP_ADD: begin
                if (cnt != 32'hFFFF_FFFF) begin
                  cnt <= cnt + 32'd1;
                end
                state <= ST_SRCH;
              end
              default: begin
                bin   <= IDX_W'(slot);
                state <= ST_RD_WAIT;
              end
            endcase
          end
        end
        ST_SRCH: begin
          if ($signed(val_r) > $signed(e_cur)) begin
            prev_e <= e_cur;
            bin    <= bin + IDX_W'(1);
            if (bin == n_act) begin
              mstep <= 3'd0;
              acc_a <= '0;
              acc_b <= '0;
              state <= ST_MUL;
            end
          end else begin
            w_r   <= e_cur - prev_e;
            mstep <= 3'd0;
            acc_a <= '0;
            acc_b <= '0;
            state <= ST_MUL;
          end
        end
        ST_RD_WAIT: begin
          state <= ST_RD_GET;
        end
        ST_RD_GET: begin
          s_r   <= sum_qv ? sum_q : 64'd0;
          s2_r  <= sum_qv ? sq_q : 63'd0;
          mstep <= 3'd0;
          acc_a <= '0;
          acc_b <= '0;
          if ({25'd0, slot_r} > 32'(n_act) + 32'd1) begin
            result_valid   <= 1'b1;
            landed_bin     <= slot_r;
            bin_sum        <= 64'd0;
            bin_square_sum <= 63'd0;
            bin_deviation  <= 32'd0;
            events_seen    <= cnt;
            state          <= ST_IDLE;
          end else if (cnt < 32'd2) begin
            result_valid   <= 1'b1;
            landed_bin     <= slot_r;
            bin_sum        <= sum_qv ? sum_q : 64'd0;
            bin_square_sum <= sum_qv ? sq_q : 63'd0;
            bin_deviation  <= 32'd0;
            events_seen    <= cnt;
            state          <= ST_IDLE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          mstep <= mstep + 3'd1;
          if (mstep != 3'd0) begin
            if (acc_to_a) begin
              acc_a <= acc_a + acc_term[95:0];
            end else begin
              acc_b <= acc_b + acc_term;
            end
          end
          if (mstep == nops) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          dv_rem <= 64'd0;
          dv_cnt <= 7'd0;
          djob   <= 1'b0;
          if (!is_dev) begin
            if (bin == '0 || bin > n_act) begin
              ds_r  <= {16'd0, mag_r, 16'd0};
              dq_r  <= acc_b[62:0];
              state <= ST_UPD;
            end else begin
              dv_d   <= {32'd0, mag_r, 32'd0};
              dv_den <= {32'd0, w_r};
              state  <= ST_DIV;
            end
          end else if (a128 <= acc_b) begin
            result_valid   <= 1'b1;
            landed_bin     <= slot_r;
            bin_sum        <= s_r;
            bin_square_sum <= s2_r;
            bin_deviation  <= 32'd0;
            events_seen    <= cnt;
            state          <= ST_IDLE;
          end else begin
            dv_d   <= diff[127:32];
            dv_den <= {32'd0, cnt - 32'd1};
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          dv_rem <= dv_ge ? 64'(dv_r2 - {1'b0, dv_den}) : dv_r2[63:0];
          dv_d   <= {dv_d[94:0], dv_ge};
          dv_cnt <= dv_cnt + 7'd1;
          if (dv_cnt == DIV_LAST) begin
            state <= ST_DFIN;
          end
        end
        ST_DFIN: begin
          dv_rem <= 64'd0;
          dv_cnt <= 7'd0;
          if (!is_dev) begin
            if (!djob) begin
              ds_r   <= (|dv_d[95:63]) ? SUM_MIN : dv_d[63:0];
              dv_d   <= {acc_b[63:0], 32'd0};
              dv_den <= acc_a[63:0];
              djob   <= 1'b1;
              state  <= ST_DIV;
            end else begin
              dq_r  <= (|dv_d[95:63]) ? SUM_MAX[62:0] : dv_d[62:0];
              state <= ST_UPD;
            end
          end else if (|dv_d[95:64]) begin
            result_valid   <= 1'b1;
            landed_bin     <= slot_r;
            bin_sum        <= s_r;
            bin_square_sum <= s2_r;
            bin_deviation  <= 32'hFFFF_FFFF;
            events_seen    <= cnt;
            state          <= ST_IDLE;
          end else begin
            sq_x   <= dv_d[63:0];
            sq_res <= 64'd0;
            sq_bit <= 64'd1 << 62;
            sq_cnt <= 5'd0;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_x >= sq_t) begin
            sq_x <= sq_x - sq_t;
          end
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == SQRT_LAST) begin
            result_valid   <= 1'b1;
            landed_bin     <= slot_r;
            bin_sum        <= s_r;
            bin_square_sum <= s2_r;
            bin_deviation  <= sq_res_next[31:0];
            events_seen    <= cnt;
            state          <= ST_IDLE;
          end
        end
        ST_UPD: begin
          sum_vld[bin]   <= 1'b1;
          result_valid   <= 1'b1;
          landed_bin     <= 7'(bin);
          bin_sum        <= new_s;
          bin_square_sum <= new_q;
          bin_deviation  <= 32'd0;
          events_seen    <= cnt;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/whf_check.sv -----
// ----------------------------------------------------------------------------
// Weighted histogram fill checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module whf_check (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input whf_pkg::opcode_t    opcode,
  input logic                result_valid,
  input logic [31:0]         bin_deviation,
  input logic [31:0]         events_seen
);
  import whf_pkg::*;

  // A clear or an edge load is answered on the very next cycle.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == OP_CLEAR || opcode == OP_LOAD) |=> result_valid)
    else $error("short request not answered on the next cycle");

  // Adding a sample or reading a bin keeps the core busy.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (opcode == OP_ADD || opcode == OP_READ) |=> busy && !result_valid)
    else $error("long request not held busy");

  // A result only appears once the core has gone idle again.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // A deviation needs at least two events.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && events_seen < 32'd2 |-> bin_deviation == 32'd0)
    else $error("deviation reported below two events");

endmodule

bind weighted_histogram_fill_core whf_check u_whf_check (.*);

// ----- verif/tb_weighted_histogram_fill_core.sv -----
// ----------------------------------------------------------------------------
// Weighted histogram fill core testbench
// Drives clear, load edge, add sample and read bin requests, mostly with random
// gaps, predicts every result from a local model of the edge table, bin sums
// and event count, and checks each result field by field as it is strobed out.
// ----------------------------------------------------------------------------
module tb_weighted_histogram_fill_core;
  timeunit 1ns;
  timeprecision 1ps;
  import whf_pkg::*;

  localparam int NBINS = 64;

  typedef struct packed {
    logic [6:0]  bin;
    logic [63:0] sum;
    logic [62:0] square_sum;
    logic [31:0] dev;
    logic [31:0] events;
  } bin_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  opcode_t            opcode;
  logic [6:0]         slot;
  logic signed [31:0] sample_value;
  logic signed [31:0] sample_weight;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;
  logic               result_valid;
  logic [6:0]         landed_bin;
  logic signed [63:0] bin_sum;
  logic [62:0]        bin_square_sum;
  logic [31:0]        bin_deviation;
  logic [31:0]        events_seen;

  weighted_histogram_fill_core #(.MAX_BINS(NBINS)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .slot(slot),
    .sample_value(sample_value), .sample_weight(sample_weight),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .landed_bin(landed_bin), .bin_sum(bin_sum),
    .bin_square_sum(bin_square_sum), .bin_deviation(bin_deviation),
    .events_seen(events_seen)
  );

  logic [31:0] edge_values [NBINS+1];
  logic [63:0] bin_sums [NBINS+2];
  logic [63:0] bin_squares [NBINS+2];
  logic [31:0] event_count;
  logic [6:0]  bins_setting;
  bin_result_t expected_results [$];
  int          mismatch_count;
  bit          sender_gaps;
  logic [31:0] edge_step;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int active_bins();
    if (bins_setting < 7'd1) return 1;
    if (bins_setting > 7'(NBINS)) return NBINS;
    return int'(bins_setting);
  endfunction

  function automatic logic [31:0] order_key(logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

  function automatic logic [63:0] scaled_quotient(logic [63:0] num, logic [63:0] den);
    logic [127:0] wide;
    if (den == 64'd0) return SUM_MIN;
    wide = ({64'd0, num} << 31) / {64'd0, den};
    if (wide >= 128'h4000_0000_0000_0000) return SUM_MIN;
    wide = ({64'd0, num} << 32) / {64'd0, den};
    return wide[63:0];
  endfunction

  function automatic logic [63:0] add_signed_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (((a ^ b) & SUM_MIN) == 64'd0 && ((r ^ a) & SUM_MIN) != 64'd0)
      return a[63] ? SUM_MIN : SUM_MAX;
    return r;
  endfunction

  function automatic logic [63:0] add_unsigned_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    if (r > {1'b0, SUM_MAX}) return SUM_MAX;
    return r[63:0];
  endfunction

  function automatic logic [31:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] bin_std_dev(logic [63:0] s, logic [63:0] s2);
    logic [63:0]  mag;
    logic [127:0] lhs;
    logic [127:0] rhs;
    logic [127:0] q;
    if (event_count < 32'd2) return 32'd0;
    mag = s[63] ? (64'd0 - s) : s;
    lhs = ({96'd0, event_count} * {64'd0, s2}) << 32;
    rhs = {64'd0, mag} * {64'd0, mag};
    if (lhs <= rhs) return 32'd0;
    q = ((lhs - rhs) >> 32) / {96'd0, event_count - 32'd1};
    if (q[127:64] != 64'd0) return 32'hFFFF_FFFF;
    return int_sqrt(q[63:0]);
  endfunction

  function automatic bin_result_t predict_request(opcode_t op, logic [6:0] s,
                                                  logic [31:0] val, logic [31:0] wgt);
    bin_result_t r;
    int          n;
    int          b;
    logic [63:0] mag;
    logic [63:0] ds;
    logic [63:0] dq;
    logic [63:0] w;
    n = active_bins();
    r = '0;
    case (op)
      OP_CLEAR: begin
        foreach (bin_sums[i]) begin
          bin_sums[i] = 64'd0;
          bin_squares[i] = 64'd0;
        end
        event_count = 32'd0;
      end
      OP_LOAD: begin
        if (s <= 7'(NBINS)) edge_values[s] = val;
        r.bin = s;
        r.events = event_count;
      end
      OP_ADD: begin
        mag = wgt[31] ? (64'h1_0000_0000 - {32'd0, wgt}) : {32'd0, wgt};
        if (event_count != 32'hFFFF_FFFF) event_count++;
        b = 0;
        while (order_key(val) > order_key(edge_values[b])) begin
          b++;
          if (b == n + 1) break;
        end
        if (b == 0 || b > n) begin
          ds = mag << 16;
          dq = mag * mag;
        end else begin
          w = {32'd0, order_key(edge_values[b])} - {32'd0, order_key(edge_values[b-1])};
          ds = scaled_quotient(mag, w);
          dq = scaled_quotient(mag * mag, w * w);
          if (!wgt[31] && ds > SUM_MAX) ds = SUM_MAX;
          if (dq > SUM_MAX) dq = SUM_MAX;
        end
        if (wgt[31]) ds = 64'd0 - ds;
        bin_sums[b] = add_signed_sat(bin_sums[b], ds);
        bin_squares[b] = add_unsigned_sat(bin_squares[b], dq);
        r.bin = 7'(b);
        r.sum = bin_sums[b];
        r.square_sum = bin_squares[b][62:0];
        r.events = event_count;
      end
      OP_READ: begin
        r.bin = s;
        r.events = event_count;
        if (int'(s) <= n + 1) begin
          r.sum = bin_sums[s];
          r.square_sum = bin_squares[s][62:0];
          r.dev = bin_std_dev(bin_sums[s], bin_squares[s]);
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {57'd0, landed_bin}, 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (landed_bin !== want.bin)
          report_mismatch("landed_bin", 64'(landed_bin), 64'(want.bin));
        if (bin_sum !== want.sum) report_mismatch("bin_sum", bin_sum, want.sum);
        if (bin_square_sum !== want.square_sum)
          report_mismatch("bin_square_sum", 64'(bin_square_sum), 64'(want.square_sum));
        if (bin_deviation !== want.dev)
          report_mismatch("bin_deviation", 64'(bin_deviation), 64'(want.dev));
        if (events_seen !== want.events)
          report_mismatch("events_seen", 64'(events_seen), 64'(want.events));
      end
    end
  end

  task automatic send_request(opcode_t op, logic [6:0] s, logic [31:0] val,
                              logic [31:0] wgt);
    int gap;
    gap = sender_gaps ? $urandom_range(17, 0) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    slot <= s;
    sample_value <= val;
    sample_weight <= wgt;
    do @(posedge clk); while (busy);
    expected_results.insert(expected_results.size(), predict_request(op, s, val, wgt));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_bins_in_use(logic [6:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bins_setting = v;
  endtask

  // Loads an ascending edge set for the current bin count.
  task automatic load_sorted_edges();
    logic [31:0] base;
    edge_step = $urandom_range(1, 32'h0010_0000);
    base = $urandom_range(32'h0080_0000, 0) - 32'h0040_0000;
    for (int i = 0; i <= active_bins(); i++)
      send_request(OP_LOAD, 7'(i), base + edge_step * i, '0);
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    int k;
    if ($urandom_range(4, 0) == 0) return $urandom();
    k = $urandom_range(active_bins(), 0);
    return edge_values[k] + $urandom_range(2 * edge_step, 0) - edge_step;
  endfunction

  task automatic test_directed();
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_LOAD, 7'd0, 32'h8000_0000, '0);
    send_request(OP_LOAD, 7'd1, 32'h8000_0001, '0);
    for (int i = 2; i <= 8; i++) send_request(OP_LOAD, 7'(i), (i - 4) << 16, '0);
    send_request(OP_ADD, '0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_ADD, '0, 32'h8000_0001, 32'h7FFF_FFFF);
    send_request(OP_ADD, '0, 32'h8000_0001, 32'h8000_0000);
    send_request(OP_ADD, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_ADD, '0, 32'h0000_8000, 32'h0001_0000);
    send_request(OP_ADD, '0, 32'h0000_C000, 32'h0000_0000);
    send_request(OP_READ, 7'd0, '0, '0);
    send_request(OP_READ, 7'd1, '0, '0);
    send_request(OP_READ, 7'd7, '0, '0);
    send_request(OP_READ, 7'd9, '0, '0);
    send_request(OP_READ, 7'd127, '0, '0);
    send_request(OP_LOAD, 7'd65, 32'hFFFF_FFFF, '0);
    send_request(OP_LOAD, 7'd127, 32'hFFFF_FFFF, '0);
    send_request(OP_CLEAR, '0, '0, '0);
    send_request(OP_READ, 7'd1, '0, '0);
  endtask

  task automatic test_bin_counts();
    logic [6:0] counts [5] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd5};
    foreach (counts[i]) begin
      write_bins_in_use(counts[i]);
      load_sorted_edges();
      for (int j = 0; j < 6; j++) send_request(OP_ADD, '0, pick_value(), pick_weight());
      send_request(OP_READ, 7'(active_bins() + 1), '0, '0);
      send_request(OP_READ, 7'(active_bins() + 2), '0, '0);
      send_request(OP_READ, 7'd1, '0, '0);
    end
  endtask

  task automatic test_random_fill();
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      write_bins_in_use(phase == 0 ? 7'($urandom_range(127, 0)) : 7'($urandom_range(12, 1)));
      sender_gaps = (phase % 3) != 1;
      load_sorted_edges();
      for (int i = 0; i < 60; i++) begin
        pick = $urandom_range(99, 0);
        if (pick < 55) begin
          send_request(OP_ADD, 7'($urandom()), pick_value(), pick_weight());
        end else if (pick < 85) begin
          send_request(OP_READ, pick < 82 ? 7'($urandom_range(active_bins() + 1, 0))
                                          : 7'($urandom()), $urandom(), $urandom());
        end else if (pick < 95) begin
          send_request(OP_LOAD, 7'($urandom_range(127, 0)), pick_value(), $urandom());
        end else begin
          send_request(OP_CLEAR, 7'($urandom()), $urandom(), $urandom());
        end
      end
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_CLEAR;
    slot = '0;
    sample_value = '0;
    sample_weight = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    sender_gaps = 1'b1;
    edge_step = 32'd1;
    bins_setting = 7'd8;
    event_count = '0;
    foreach (edge_values[i]) edge_values[i] = '0;
    foreach (bin_sums[i]) begin
      bin_sums[i] = '0;
      bin_squares[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_bin_counts();
    test_random_fill();
    drain_results();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/whf_pkg.sv
src/weighted_histogram_fill_core.sv
src/whf_check.sv
verif/tb_weighted_histogram_fill_core.sv
